// ===== design/grid_dda_column_raycast_defines.svh =====
// Assertion macros for the grid DDA column ray caster.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef GRID_DDA_COLUMN_RAYCAST_DEFINES_SVH
`define GRID_DDA_COLUMN_RAYCAST_DEFINES_SVH

// Same-cycle implication check.
`define GDCR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid_dda_column_raycast: assertion failed");

// Next-cycle implication check.
`define GDCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid_dda_column_raycast: assertion failed");

`endif

// ===== design/gdcr_pkg.sv =====
// Shared types, widths and constants of the grid DDA column ray caster.
// No dependencies; every design file but gdcr_ram and the defines header imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gdcr_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int MAP_SIDE      = 64;
  localparam int MAX_STEPS     = 128;

  localparam int COL_W   = 10;
  localparam int COORD_W = 6;
  localparam int CELL_W  = 8;
  localparam int DIST_W  = 24;
  localparam int LH_W    = 12;
  localparam int ROW_W   = 9;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 16;
  localparam int FRAC_W    = 10;
  localparam int VEC_W     = 16;
  localparam int ANG_FRAC  = 14;
  localparam int CAM_W     = 18;
  localparam int PROD_W    = VEC_W + CAM_W;
  localparam int RAY_W     = 21;

  localparam int MAP_BITS  = $clog2(MAP_SIDE);
  localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int MPOS_W    = MAP_BITS + 2;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int SD_W      = DIST_W + STEP_W + 1;
  localparam int NUMS_W    = MPOS_W + FRAC_W + 2;
  localparam int ROWC_W    = LH_W + 1;

  localparam int NUM_W      = 38;
  localparam int DEN_W      = DIST_W;
  localparam int DIV_BITS   = 2;
  localparam int DIV_ITERS  = NUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  localparam int CAM_ONE      = 1 << ANG_FRAC;
  localparam int CAM_SHIFT    = ANG_FRAC + 1;
  localparam int RECIP_SHIFT  = 30;
  localparam int DIST_SHIFT   = 20;
  localparam int HEIGHT_SHIFT = 16;
  localparam int FRAC_ONE     = 1 << FRAC_W;
  localparam int LH_MAX       = (1 << LH_W) - 1;
  localparam int HALF_H       = SCREEN_HEIGHT / 2;

  // The column scale by the screen width is a multiplication by a rounded-up
  // reciprocal, exact for every 10-bit column.
  localparam int     CAM_RECIP_K    = 39;
  localparam int     CAM_RECIP_W    = CAM_RECIP_K + 1 - $clog2(SCREEN_WIDTH);
  localparam int     CAM_PROD_W     = COL_W + CAM_RECIP_W;
  localparam int     CAM_PROD_SHIFT = CAM_RECIP_K - CAM_SHIFT;
  localparam longint CAM_RECIP      = ((longint'(1) << CAM_RECIP_K) +
                                       longint'(SCREEN_WIDTH) - 1) / longint'(SCREEN_WIDTH);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [DIST_W-1:0] ONE_Q16  = DIST_W'(65536);

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        [POS_W-1:0] pos_x;
    logic        [POS_W-1:0] pos_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
  } cam_cfg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [COL_W-1:0]  column;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] value;
  } qent_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    B_CLEAR, B_IDLE, B_CAM, B_RAY, B_DIR, B_DXS, B_DXW, B_DYS, B_DYW,
    B_SIDE, B_STEP, B_READ, B_WDS, B_WDW, B_LHS, B_LHW, B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/grid_dda_column_raycast.sv =====
// Top level of the grid DDA column ray caster: camera registers, front end,
// work queue and back end. Depends on gdcr_pkg, gdcr_front, gdcr_fifo, gdcr_back.
//
//   channel | direction | handshake            | payload
//   in_*    | input     | in_valid / in_stall   | action, column, cell x/y, cell value
//   out_*   | output    | out_valid / out_stall | column, hit, side, cell, value, rows
//   cfg_*   | input     | cfg_we                | register index, 16-bit data
//
// A map write is done in the back end from the idle state; a cast walks at most
// MAX_STEPS cells with one map RAM read per DDA step and uses the shared divider
// for up to four divisions (ray deltas, wall distance and line height).
// After reset a clearing pass over all MAP_SIDE*MAP_SIDE (4096) cells zeroes the map,
// during which in_stall is high. Output results wait in a register while
// out_stall is high, and up to two items queue in front of the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_dda_column_raycast_defines.svh"

module grid_dda_column_raycast (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic                           in_action,
  input  wire logic [gdcr_pkg::COL_W-1:0]     in_column,
  input  wire logic [gdcr_pkg::COORD_W-1:0]   in_cell_x,
  input  wire logic [gdcr_pkg::COORD_W-1:0]   in_cell_y,
  input  wire logic [gdcr_pkg::CELL_W-1:0]    in_cell_value,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [gdcr_pkg::COL_W-1:0]     out_column,
  output      logic                           out_hit_found,
  output      logic                           out_hit_side,
  output      logic [gdcr_pkg::COORD_W-1:0]   out_hit_x,
  output      logic [gdcr_pkg::COORD_W-1:0]   out_hit_y,
  output      logic [gdcr_pkg::CELL_W-1:0]    out_wall_value,
  output      logic [gdcr_pkg::DIST_W-1:0]    out_wall_dist,
  output      logic [gdcr_pkg::LH_W-1:0]      out_line_height,
  output      logic [gdcr_pkg::ROW_W-1:0]     out_draw_start,
  output      logic [gdcr_pkg::ROW_W-1:0]     out_draw_end,
  input  wire logic                           cfg_we,
  input  wire logic [gdcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gdcr_pkg::CFG_W-1:0]     cfg_data
);

  import gdcr_pkg::*;

  cam_cfg_t cfg_r;
  logic     clearing;
  logic     q_push;
  qent_t    q_entry;
  logic     q_full;
  logic     q_pop;
  qent_t    q_head;
  logic     q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x   <= POS_W'(32768);
      cfg_r.pos_y   <= POS_W'(32768);
      cfg_r.dir_x   <= -VEC_W'(16384);
      cfg_r.dir_y   <= '0;
      cfg_r.plane_x <= '0;
      cfg_r.plane_y <= VEC_W'(10813);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POS_X:   cfg_r.pos_x   <= cfg_data;
        CFG_POS_Y:   cfg_r.pos_y   <= cfg_data;
        CFG_DIR_X:   cfg_r.dir_x   <= cfg_data;
        CFG_DIR_Y:   cfg_r.dir_y   <= cfg_data;
        CFG_PLANE_X: cfg_r.plane_x <= cfg_data;
        CFG_PLANE_Y: cfg_r.plane_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gdcr_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_column    (in_column),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .in_cell_value(in_cell_value),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  gdcr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  gdcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column     (out_column),
    .out_hit_found  (out_hit_found),
    .out_hit_side   (out_hit_side),
    .out_hit_x      (out_hit_x),
    .out_hit_y      (out_hit_y),
    .out_wall_value (out_wall_value),
    .out_wall_dist  (out_wall_dist),
    .out_line_height(out_line_height),
    .out_draw_start (out_draw_start),
    .out_draw_end   (out_draw_end)
  );

  `GDCR_ASSERT_IMPL(a_clear_blocks_input, clearing, in_stall)
  `GDCR_ASSERT_NEXT(a_clear_once, !clearing, !clearing)
  `GDCR_ASSERT_IMPL(a_hit_has_dist, out_valid && out_hit_found, out_wall_dist != '0)
  `GDCR_ASSERT_IMPL(a_rows_ordered, out_valid && out_hit_found, out_draw_start <= out_draw_end)
  `GDCR_ASSERT_IMPL(a_miss_is_blank, out_valid && !out_hit_found, out_wall_dist == '0 && out_line_height == '0)

endmodule

`default_nettype wire

// ===== design/gdcr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gdcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== design/gdcr_front.sv =====
// Front end: accepts input beats, classifies them and queues the work.
// Depends on gdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdcr_front (
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_action,
  input  wire logic [gdcr_pkg::COL_W-1:0]  in_column,
  input  wire logic [gdcr_pkg::COORD_W-1:0] in_cell_x,
  input  wire logic [gdcr_pkg::COORD_W-1:0] in_cell_y,
  input  wire logic [gdcr_pkg::CELL_W-1:0] in_cell_value,
  input  wire logic                        clearing,
  input  wire logic                        q_full,
  output      logic                        q_push,
  output      gdcr_pkg::qent_t             q_entry
);

  import gdcr_pkg::*;

  logic in_range;

  always_comb begin
    in_stall = clearing || q_full;
    in_range = (int'(in_cell_x) < MAP_SIDE) && (int'(in_cell_y) < MAP_SIDE);
    q_entry.op     = in_action ? OP_CAST : OP_WRITE;
    q_entry.column = in_column;
    q_entry.addr   = ADDR_W'(in_cell_y) * ADDR_W'(MAP_SIDE) + ADDR_W'(in_cell_x);
    q_entry.value  = in_cell_value;
    // Writes outside the map are taken and dropped.
    q_push = in_valid && !in_stall && (in_action || in_range);
  end

endmodule

`default_nettype wire

// ===== design/gdcr_fifo.sv =====
// Short work queue between the front end and the back end.
// Depends on gdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdcr_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire gdcr_pkg::qent_t push_data,
  output      logic            full,
  input  wire logic            pop,
  output      gdcr_pkg::qent_t head,
  output      logic            empty
);

  import gdcr_pkg::*;

  qent_t             mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r;
  logic [FPTR_W-1:0] rd_ptr_r;
  logic [FCNT_W-1:0] cnt_r;

  function automatic logic [FPTR_W-1:0] ptr_inc(input logic [FPTR_W-1:0] p);
    return (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/gdcr_div.sv =====
// Shared iterative unsigned divider, two quotient bits per cycle.
// Depends on gdcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdcr_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gdcr_pkg::div_req_t req,
  output      gdcr_pkg::div_rsp_t rsp
);

  import gdcr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]     quot_r;
  logic [DEN_W:0]       rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [NUM_W-1:0]     quot_nxt;
  logic [DEN_W:0]       rem_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_nxt  = {rem_nxt[DEN_W-1:0], quot_nxt[NUM_W-1]};
      quot_nxt = {quot_nxt[NUM_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, den_r}) begin
        rem_nxt     = rem_nxt - {1'b0, den_r};
        quot_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.num;
      rem_r  <= '0;
      den_r  <= req.den;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ===== design/gdcr_back.sv =====
// Back end: map writes, map clearing, ray setup, DDA walk, distance and line height math.
// Depends on gdcr_pkg, gdcr_ram and gdcr_div.
`timescale 1ns / 1ps
`default_nettype none

module gdcr_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gdcr_pkg::cam_cfg_t           cfg,
  input  wire logic                         q_empty,
  input  wire gdcr_pkg::qent_t              q_head,
  output      logic                         q_pop,
  output      logic                         clearing,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [gdcr_pkg::COL_W-1:0]   out_column,
  output      logic                         out_hit_found,
  output      logic                         out_hit_side,
  output      logic [gdcr_pkg::COORD_W-1:0] out_hit_x,
  output      logic [gdcr_pkg::COORD_W-1:0] out_hit_y,
  output      logic [gdcr_pkg::CELL_W-1:0]  out_wall_value,
  output      logic [gdcr_pkg::DIST_W-1:0]  out_wall_dist,
  output      logic [gdcr_pkg::LH_W-1:0]    out_line_height,
  output      logic [gdcr_pkg::ROW_W-1:0]   out_draw_start,
  output      logic [gdcr_pkg::ROW_W-1:0]   out_draw_end
);

  import gdcr_pkg::*;

  back_state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]         column_r, column_nxt;
  logic signed [CAM_W-1:0]  cam_r, cam_nxt;
  logic signed [PROD_W-1:0] prodx_r, prodx_nxt, prody_r, prody_nxt;
  logic signed [RAY_W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [DIST_W-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SD_W-1:0]          sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic signed [MPOS_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic                     side_r, side_nxt;
  logic [STEP_W-1:0]        steps_r, steps_nxt;
  logic                     hit_r, hit_nxt;
  logic [CELL_W-1:0]        wv_r, wv_nxt;
  logic [DIST_W-1:0]        wd_r, wd_nxt;
  logic [LH_W-1:0]          lh_r, lh_nxt;
  logic                     out_valid_r;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [CELL_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [CELL_W-1:0]        ram_rdata;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     emit;
  logic [CAM_PROD_W-1:0]    cam_prod;
  logic [RAY_W-1:0]         mag_rx, mag_ry;
  logic [FRAC_W:0]          frac_x, frac_y;
  logic [FRAC_W+DIST_W:0]   sdx_prod, sdy_prod;
  logic                     in_map;
  logic signed [NUMS_W-1:0] cell_ext, num_s;
  logic signed [RAY_W-1:0]  den_s;
  logic [NUMS_W-1:0]        mag_num;
  logic [RAY_W-1:0]         mag_den;
  logic [POS_W-1:0]         pos_sel;
  logic                     neg_sel;
  logic [ROWC_W-1:0]        half_lh, row_start, row_end;

  gdcr_ram #(
    .WIDTH(CELL_W),
    .DEPTH(MAP_CELLS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gdcr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  function automatic logic [DIST_W-1:0] sat_dist(input logic [NUM_W-1:0] q);
    return (q > NUM_W'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
  endfunction

  always_comb begin
    cam_prod = CAM_PROD_W'(column_r) * CAM_PROD_W'(CAM_RECIP);
    mag_rx   = (rx_r < 0) ? RAY_W'(-rx_r) : RAY_W'(rx_r);
    mag_ry   = (ry_r < 0) ? RAY_W'(-ry_r) : RAY_W'(ry_r);
    frac_x   = (rx_r < 0) ? {1'b0, cfg.pos_x[FRAC_W-1:0]}
                          : (FRAC_W+1)'(FRAC_ONE) - {1'b0, cfg.pos_x[FRAC_W-1:0]};
    frac_y   = (ry_r < 0) ? {1'b0, cfg.pos_y[FRAC_W-1:0]}
                          : (FRAC_W+1)'(FRAC_ONE) - {1'b0, cfg.pos_y[FRAC_W-1:0]};
    sdx_prod = (FRAC_W+DIST_W+1)'(frac_x) * (FRAC_W+DIST_W+1)'(dx_r);
    sdy_prod = (FRAC_W+DIST_W+1)'(frac_y) * (FRAC_W+DIST_W+1)'(dy_r);

    cell_ext = side_r ? NUMS_W'(my_r) : NUMS_W'(mx_r);
    neg_sel  = side_r ? (ry_r < 0) : (rx_r < 0);
    pos_sel  = side_r ? cfg.pos_y : cfg.pos_x;
    num_s    = ((cell_ext + NUMS_W'(neg_sel)) <<< FRAC_W) - NUMS_W'(pos_sel);
    den_s    = side_r ? ry_r : rx_r;
    mag_num  = (num_s < 0) ? NUMS_W'(-num_s) : NUMS_W'(num_s);
    mag_den  = (den_s < 0) ? RAY_W'(-den_s) : RAY_W'(den_s);

    half_lh   = ROWC_W'(lh_r[LH_W-1:1]);
    row_start = (half_lh > ROWC_W'(HALF_H)) ? '0 : ROWC_W'(HALF_H) - half_lh;
    row_end   = half_lh + ROWC_W'(HALF_H);
    if (row_end >= ROWC_W'(SCREEN_HEIGHT)) begin
      row_end = ROWC_W'(SCREEN_HEIGHT - 1);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    column_nxt   = column_r;
    cam_nxt      = cam_r;
    prodx_nxt    = prodx_r;
    prody_nxt    = prody_r;
    rx_nxt       = rx_r;
    ry_nxt       = ry_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    sdx_nxt      = sdx_r;
    sdy_nxt      = sdy_r;
    mx_nxt       = mx_r;
    my_nxt       = my_r;
    side_nxt     = side_r;
    steps_nxt    = steps_r;
    hit_nxt      = hit_r;
    wv_nxt       = wv_r;
    wd_nxt       = wd_r;
    lh_nxt       = lh_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = q_head.addr;
    ram_wdata    = q_head.value;
    div_req      = '0;
    emit         = 1'b0;
    in_map       = 1'b0;

    case (state_r)
      B_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(MAP_CELLS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            column_nxt = q_head.column;
            state_nxt  = B_CAM;
          end
        end
      end
      B_CAM: begin
        cam_nxt   = $signed(CAM_W'(cam_prod >> CAM_PROD_SHIFT)) - CAM_W'(CAM_ONE);
        state_nxt = B_RAY;
      end
      B_RAY: begin
        prodx_nxt = cfg.plane_x * cam_r;
        prody_nxt = cfg.plane_y * cam_r;
        state_nxt = B_DIR;
      end
      B_DIR: begin
        rx_nxt    = RAY_W'(prodx_r >>> ANG_FRAC) + RAY_W'(cfg.dir_x);
        ry_nxt    = RAY_W'(prody_r >>> ANG_FRAC) + RAY_W'(cfg.dir_y);
        state_nxt = B_DXS;
      end
      B_DXS: begin
        if (mag_rx == '0) begin
          dx_nxt    = DIST_MAX;
          state_nxt = B_DYS;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(1) << RECIP_SHIFT;
          div_req.den   = DEN_W'(mag_rx);
          state_nxt     = B_DXW;
        end
      end
      B_DXW: begin
        if (div_rsp.done) begin
          dx_nxt    = sat_dist(div_rsp.quot);
          state_nxt = B_DYS;
        end
      end
      B_DYS: begin
        if (mag_ry == '0) begin
          dy_nxt    = DIST_MAX;
          state_nxt = B_SIDE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(1) << RECIP_SHIFT;
          div_req.den   = DEN_W'(mag_ry);
          state_nxt     = B_DYW;
        end
      end
      B_DYW: begin
        if (div_rsp.done) begin
          dy_nxt    = sat_dist(div_rsp.quot);
          state_nxt = B_SIDE;
        end
      end
      B_SIDE: begin
        sdx_nxt   = SD_W'(sdx_prod[FRAC_W+DIST_W:FRAC_W]);
        sdy_nxt   = SD_W'(sdy_prod[FRAC_W+DIST_W:FRAC_W]);
        mx_nxt    = MPOS_W'($signed({1'b0, cfg.pos_x[POS_W-1:FRAC_W]}));
        my_nxt    = MPOS_W'($signed({1'b0, cfg.pos_y[POS_W-1:FRAC_W]}));
        side_nxt  = 1'b0;
        steps_nxt = '0;
        hit_nxt   = 1'b0;
        wv_nxt    = '0;
        state_nxt = B_STEP;
      end
      B_STEP: begin
        if (sdx_r < sdy_r) begin
          sdx_nxt  = sdx_r + SD_W'(dx_r);
          mx_nxt   = (rx_r < 0) ? mx_r - 1'b1 : mx_r + 1'b1;
          side_nxt = 1'b0;
        end else begin
          sdy_nxt  = sdy_r + SD_W'(dy_r);
          my_nxt   = (ry_r < 0) ? my_r - 1'b1 : my_r + 1'b1;
          side_nxt = 1'b1;
        end
        steps_nxt = steps_r + 1'b1;
        in_map = (mx_nxt >= 0) && (mx_nxt < MPOS_W'(MAP_SIDE)) &&
                 (my_nxt >= 0) && (my_nxt < MPOS_W'(MAP_SIDE));
        state_nxt = in_map ? B_READ : B_EMIT;
      end
      B_READ: begin
        if (ram_rdata != '0) begin
          hit_nxt   = 1'b1;
          wv_nxt    = ram_rdata;
          state_nxt = B_WDS;
        end else if (steps_r == STEP_W'(MAX_STEPS)) begin
          state_nxt = B_EMIT;
        end else begin
          state_nxt = B_STEP;
        end
      end
      B_WDS: begin
        if (!(num_s > 0) && den_s == '0) begin
          wd_nxt    = ONE_Q16;
          state_nxt = B_LHS;
        end else if (den_s == '0) begin
          wd_nxt    = DIST_MAX;
          state_nxt = B_LHS;
        end else if (num_s == '0 || ((num_s > 0) != (den_s > 0))) begin
          wd_nxt    = ONE_Q16;
          state_nxt = B_LHS;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(mag_num) << DIST_SHIFT;
          div_req.den   = DEN_W'(mag_den);
          state_nxt     = B_WDW;
        end
      end
      B_WDW: begin
        if (div_rsp.done) begin
          wd_nxt    = (div_rsp.quot == '0) ? ONE_Q16 : sat_dist(div_rsp.quot);
          state_nxt = B_LHS;
        end
      end
      B_LHS: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(SCREEN_HEIGHT) << HEIGHT_SHIFT;
        div_req.den   = DEN_W'(wd_r);
        state_nxt     = B_LHW;
      end
      B_LHW: begin
        if (div_rsp.done) begin
          lh_nxt    = (div_rsp.quot > NUM_W'(LH_MAX)) ? LH_W'(LH_MAX)
                                                     : div_rsp.quot[LH_W-1:0];
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit      = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    ram_raddr = ADDR_W'(my_nxt[MAP_BITS-1:0]) * ADDR_W'(MAP_SIDE) +
                ADDR_W'(mx_nxt[MAP_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    column_r <= column_nxt;
    cam_r    <= cam_nxt;
    prodx_r  <= prodx_nxt;
    prody_r  <= prody_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sdx_r    <= sdx_nxt;
    sdy_r    <= sdy_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    side_r   <= side_nxt;
    steps_r  <= steps_nxt;
    hit_r    <= hit_nxt;
    wv_r     <= wv_nxt;
    wd_r     <= wd_nxt;
    lh_r     <= lh_nxt;
    if (emit) begin
      out_column      <= column_r;
      out_hit_found   <= hit_r;
      out_hit_side    <= side_r;
      out_hit_x       <= mx_r[COORD_W-1:0];
      out_hit_y       <= my_r[COORD_W-1:0];
      out_wall_value  <= hit_r ? wv_r : '0;
      out_wall_dist   <= hit_r ? wd_r : '0;
      out_line_height <= hit_r ? lh_r : '0;
      out_draw_start  <= hit_r ? row_start[ROW_W-1:0] : '0;
      out_draw_end    <= hit_r ? row_end[ROW_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign clearing  = (state_r == B_CLEAR);

endmodule

`default_nettype wire
